FILE: rtl/lrbd_pkg.sv
// Package for the bounded Lehmer draw block: constants, op codes, queue entry type.
// No dependencies.
`timescale 1ns / 1ps
package lrbd_pkg;
	localparam int StateW = 31;
	localparam int BoundW = 32;
	localparam logic [15:0] LehmerMult = 16'hBC8F;
	localparam logic [30:0] LehmerMod = 31'h7FFF_FFFF;
	localparam int QDepth = 2;

	typedef enum logic [1:0] {
		OP_RAW  = 2'd0,
		OP_BYTE = 2'd1,
		OP_HALF = 2'd2,
		OP_MOD  = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [BoundW-1:0] bound;
		logic [StateW-1:0] draw;
	} entry_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_DIV  = 2'd1,
		B_OUT  = 2'd2
	} bstate_t;
endpackage

FILE: rtl/lrbd_front.sv
// Front part: holds generator state, loads seeds, advances it once per accepted item.
// Depends on lrbd_pkg.
`timescale 1ns / 1ps
module lrbd_front import lrbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  op_t               op,
	input  logic [BoundW-1:0] bound,
	input  logic              seed_we,
	input  logic [31:0]       seed,
	output logic              q_push,
	output entry_t            q_data,
	input  logic              q_full
);
	logic [StateW-1:0] state_q;
	logic [46:0] prod;
	logic [31:0] fold;
	logic [31:0] fold_r;
	logic [StateW-1:0] next_state;
	logic [31:0] sd_fold;
	logic [31:0] sd_r;
	logic [StateW-1:0] seed_state;

	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;

	// Mersenne fold: high part from bit 31 up added to the low 31 bits
	assign prod = {16'd0, state_q} * {31'd0, LehmerMult};
	assign fold = {16'd0, prod[46:31]} + {1'b0, prod[30:0]};
	assign fold_r = (fold >= {1'b0, LehmerMod}) ? fold - {1'b0, LehmerMod} : fold;
	assign next_state = fold_r[StateW-1:0];

	// seed mod 2^31-1 by folding bit 31 back in, at most one subtract
	assign sd_fold = {31'd0, seed[31]} + {1'b0, seed[30:0]};
	always_comb begin
		sd_r = sd_fold;
		if (sd_r >= {1'b0, LehmerMod}) sd_r = sd_r - {1'b0, LehmerMod};
		seed_state = (sd_r[30:0] == '0) ? 31'd1 : sd_r[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= 31'd1;
		end else if (seed_we) begin
			state_q <= seed_state;
		end else if (q_push) begin
			state_q <= next_state;
		end
	end

	assign q_data = '{op: op, bound: bound, draw: next_state};
endmodule

FILE: rtl/lrbd_queue.sv
// Two-entry FIFO between the front and back parts.
// Depends on lrbd_pkg.
`timescale 1ns / 1ps
module lrbd_queue import lrbd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wdata,
	output logic   full,
	input  logic   pop,
	output logic   nempty,
	output entry_t rdata
);
	entry_t mem_q [QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(QDepth));
	assign nempty = (cnt_q != 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

FILE: rtl/lrbd_back.sv
// Back part: narrows the draw or reduces it modulo bound with a radix-2 divider.
// Depends on lrbd_pkg.
`timescale 1ns / 1ps
module lrbd_back import lrbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_nempty,
	input  entry_t            q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [StateW-1:0] value
);
	bstate_t st_q, st_nx;
	logic [StateW-1:0] val_q;
	logic [StateW-1:0] quo_q;   // dividend bits still to shift in
	logic [BoundW-1:0] rem_q;
	logic [BoundW-1:0] bnd_q;
	logic [4:0] cnt_q;
	logic [BoundW:0] trial;
	logic [BoundW:0] diff;
	logic take;

	assign take = (st_q == B_IDLE) && q_nempty;
	assign trial = {rem_q, quo_q[StateW-1]};
	assign diff = trial - {1'b0, bnd_q};

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			B_IDLE: if (q_nempty) st_nx = (q_data.op == OP_MOD && q_data.bound != '0) ? B_DIV : B_OUT;
			B_DIV:  if (cnt_q == 5'd0) st_nx = B_OUT;
			B_OUT:  if (!out_stall) st_nx = B_IDLE;
			default: st_nx = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop = take;
		out_valid = (st_q == B_OUT);
		value = val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= B_IDLE;
		else st_q <= st_nx;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			quo_q <= q_data.draw;
			rem_q <= '0;
			bnd_q <= q_data.bound;
			cnt_q <= 5'(StateW - 1);
			unique case (q_data.op)
				OP_RAW:  val_q <= q_data.draw;
				OP_BYTE: val_q <= {23'd0, q_data.draw[7:0]};
				OP_HALF: val_q <= {15'd0, q_data.draw[15:0]};
				OP_MOD:  val_q <= '0;
				default: val_q <= '0;
			endcase
		end else if (st_q == B_DIV) begin
			// one quotient bit per cycle, restoring
			quo_q <= {quo_q[StateW-2:0], 1'b0};
			if (!diff[BoundW]) rem_q <= diff[BoundW-1:0];
			else rem_q <= trial[BoundW-1:0];
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0)
				val_q <= !diff[BoundW] ? diff[StateW-1:0] : trial[StateW-1:0];
		end
	end
endmodule

FILE: rtl/lehmer_rng_bounded_draw.sv
// Bounded Lehmer draw (multiplier 48271, modulus 2^31-1), top level.
// Flow: the back part takes a new item only once the last result has left its output register.
// Path: front to queue, then back part (op 3 via bit-serial divider) into its output register.
// Reset: async active low; generator state returns to 1, queue empty.
// Depends on lrbd_pkg, lrbd_front, lrbd_queue, lrbd_back.
`timescale 1ns / 1ps
module lehmer_rng_bounded_draw import lrbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [BoundW-1:0] bound,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [StateW-1:0] value,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data
);
	logic q_push, q_full, q_pop, q_nempty;
	entry_t q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	lrbd_front u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.op(op_t'(op)), .bound,
		.seed_we(cfg_valid), .seed(cfg_data),
		.q_push, .q_data(q_wdata), .q_full
	);

	lrbd_queue u_queue (
		.clk, .arst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
		.pop(q_pop), .nempty(q_nempty), .rdata(q_rdata)
	);

	lrbd_back u_back (
		.clk, .arst_n, .q_nempty, .q_data(q_rdata), .q_pop,
		.out_valid, .out_stall, .value
	);
endmodule

FILE: sim/tb_top.sv
// Testbench for lehmer_rng_bounded_draw: random and directed draws checked against a local
// Lehmer (48271, 2^31-1) predictor, with seed writes between phases. Depends on lrbd_pkg and the top level.
`timescale 1ns / 1ps
module tb_top;
	import lrbd_pkg::*;

	typedef struct {
		op_t         op;
		logic [31:0] bound;
	} draw_req_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        op = '0;
	logic [31:0]       bound = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [30:0]       value;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [31:0]       cfg_data = '0;

	draw_req_t   pending_reqs[$];
	logic [30:0] expected_values[$];
	logic [30:0] gen_state;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          error_count = 0;
	int          cycle_count = 0;
	bit          in_flight = 1'b0;

	always #1 clk = ~clk;

	lehmer_rng_bounded_draw DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .bound(bound),
		.out_valid(out_valid), .out_stall(out_stall), .value(value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	function automatic logic [30:0] seed_state(logic [31:0] s);
		logic [31:0] v;
		v = s % 32'h7FFF_FFFF;
		return (v == 0) ? 31'd1 : v[30:0];
	endfunction

	function automatic logic [30:0] lehmer_advance(logic [30:0] s);
		logic [63:0] prod;
		logic [63:0] sum;
		prod = 64'd48271 * s;
		sum = (prod >> 31) + (prod & 64'h7FFF_FFFF);
		if (sum >= 64'h7FFF_FFFF)
			sum -= 64'h7FFF_FFFF;
		return sum[30:0];
	endfunction

	function automatic logic [30:0] predict_draw(draw_req_t r);
		logic [30:0] d;
		gen_state = lehmer_advance(gen_state);
		d = gen_state;
		case (r.op)
			OP_RAW: return d;
			OP_BYTE: return {23'd0, d[7:0]};
			OP_HALF: return {15'd0, d[15:0]};
			default: return (r.bound == 0) ? 31'd0 : 31'({1'b0, d} % r.bound);
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	// driver: presents queued requests, predicts at each accepted transfer
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_values.push_back(predict_draw('{op_t'(op), bound}));
			in_flight = 1'b0;
		end
		if (!in_valid || !in_stall) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				draw_req_t r;
				r = pending_reqs.pop_front();
				op <= r.op;
				bound <= r.bound;
				in_valid <= 1'b1;
				in_flight = 1'b1;
			end else begin
				in_valid <= 1'b0;
				op <= 2'($urandom);
				bound <= $urandom;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_values.size() == 0)
				report_mismatch($sformatf("unexpected value %0d", value));
			else begin
				logic [30:0] e;
				e = expected_values.pop_front();
				if (value !== e)
					report_mismatch($sformatf("value %0d, expected %0d", value, e));
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_flight || in_valid || expected_values.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_seed(logic [31:0] s);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= s;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gen_state = seed_state(s);
	endtask

	function automatic draw_req_t rand_req();
		draw_req_t r;
		r.op = op_t'($urandom_range(3));
		case ($urandom_range(5))
			0: r.bound = 0;
			1: r.bound = $urandom_range(16, 1);
			2: r.bound = 32'hFFFF_FFFF - $urandom_range(3);
			3: r.bound = 32'h7FFF_FFFF - 2 + $urandom_range(3);
			default: r.bound = $urandom;
		endcase
		return r;
	endfunction

	task automatic run_phase(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n) pending_reqs.push_back(rand_req());
		wait_drained();
	endtask

	initial begin
		logic [31:0] dir_bounds[8];
		dir_bounds = '{0, 1, 2, 255, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
		gen_state = 31'd1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: every op and the extremes of bound
		foreach (dir_bounds[i])
			pending_reqs.push_back('{OP_MOD, dir_bounds[i]});
		pending_reqs.push_back('{OP_RAW, 32'hFFFF_FFFF});
		pending_reqs.push_back('{OP_BYTE, 32'h0});
		pending_reqs.push_back('{OP_HALF, 32'h5555_AAAA});
		pending_reqs.push_back('{OP_RAW, 32'h0});
		wait_drained();
		// seeds that reduce to zero, and the top of the range
		write_seed(32'd0);
		run_phase(4, 0, 0);
		write_seed(32'h7FFF_FFFF);
		run_phase(4, 0, 0);
		write_seed(32'hFFFF_FFFE);
		run_phase(4, 0, 0);
		write_seed(32'hFFFF_FFFF);
		run_phase(200, 0, 0);
		write_seed(32'h7FFF_FFFE);
		run_phase(300, 75, 0);
		write_seed($urandom);
		run_phase(300, 0, 75);
		write_seed($urandom);
		run_phase(330, 14, 14);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

FILE: files.f
rtl/lrbd_pkg.sv
rtl/lrbd_front.sv
rtl/lrbd_queue.sv
rtl/lrbd_back.sv
rtl/lehmer_rng_bounded_draw.sv
sim/tb_top.sv
